FILE: rtl/core/zbr_pkg.sv
// shared types and constants for the zone bandwidth reservation unit
`timescale 1ns / 1ps
package zbr_pkg;

  localparam int ZBR_ZONES  = 16;
  localparam int ZONE_W     = 4;
  localparam int ZONE_EXT_W = 9;
  localparam int AMT_W      = 64;
  localparam int GRANT_W    = 32;

  localparam logic [AMT_W-1:0] HANDLE_ODD = 64'h1;

  typedef enum logic [1:0] {
    KIND_SET      = 2'd0,
    KIND_SCHEDULE = 2'd1,
    KIND_RELEASE  = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [AMT_W-1:0]   budget;
    logic [AMT_W-1:0]   in_use;
    logic [AMT_W-1:0]   queued;
    logic [GRANT_W-1:0] grants;
    logic [AMT_W-1:0]   hcount;
  } entry_t;

  typedef struct packed {
    logic [AMT_W-1:0]   handle;
    logic [AMT_W-1:0]   in_use;
    logic [AMT_W-1:0]   queued;
    logic [GRANT_W-1:0] grants;
  } result_t;

endpackage

FILE: rtl/core/zbr_table.sv
// zone table memory with per-entry valid bits
`timescale 1ns / 1ps
module zbr_table #(
  parameter int ZONES = zbr_pkg::ZBR_ZONES,
  localparam int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output zbr_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  zbr_pkg::entry_t wr_data
);
  import zbr_pkg::*;

  entry_t             mem [ZONES];
  entry_t             rd_q;
  logic               rd_hit;
  logic [ZONES-1:0]   vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= vld[rd_idx];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_hit ? rd_q : '0;

endmodule

FILE: rtl/core/zbr_update.sv
// read-modify-write update of one zone entry and its result
`timescale 1ns / 1ps
module zbr_update (
  input  zbr_pkg::kind_t   kind,
  input  logic [63:0]      amount,
  input  logic             zone_ok,
  input  zbr_pkg::entry_t  cur,
  output zbr_pkg::entry_t  nxt,
  output zbr_pkg::result_t res
);
  import zbr_pkg::*;

  logic [AMT_W:0]   use_sum;
  logic [AMT_W:0]   q_sum;
  logic [AMT_W-1:0] hcount_inc;
  logic [AMT_W-1:0] handle_val;

  always_comb begin
    use_sum    = {1'b0, cur.in_use} + {1'b0, amount};
    q_sum      = {1'b0, cur.queued} + {1'b0, amount};
    hcount_inc = cur.hcount + 64'd1;
    nxt        = cur;
    handle_val = '0;
    unique case (kind)
      KIND_SET: begin
        nxt.budget = amount;
      end
      KIND_SCHEDULE: begin
        if (cur.budget == '0) begin
          handle_val = HANDLE_ODD;
        end else if (use_sum <= {1'b0, cur.budget}) begin
          nxt.in_use = use_sum[AMT_W-1:0];
          if (cur.grants != '1) begin
            nxt.grants = cur.grants + 32'd1;
          end
          nxt.hcount = hcount_inc;
          handle_val = hcount_inc | HANDLE_ODD;
        end else begin
          nxt.queued = q_sum[AMT_W] ? '1 : q_sum[AMT_W-1:0];
        end
      end
      KIND_RELEASE: begin
        if (cur.grants != '0) begin
          nxt.grants = cur.grants - 32'd1;
          if (cur.grants == 32'd1) begin
            nxt.in_use = '0;
            nxt.queued = '0;
          end
        end
      end
      KIND_STATUS: begin
      end
    endcase
  end

  always_comb begin
    if (zone_ok) begin
      res.handle = handle_val;
      res.in_use = nxt.in_use;
      res.queued = nxt.queued;
      res.grants = nxt.grants;
    end else begin
      // zone outside the table
      res.handle = (kind == KIND_SCHEDULE) ? HANDLE_ODD : '0;
      res.in_use = '0;
      res.queued = '0;
      res.grants = '0;
    end
  end

endmodule

FILE: rtl/core/zone_bandwidth_reservation_unit.sv
// top level of the zone bandwidth reservation unit
//
// Requests arrive on the in channel (kind, zone, amount) under in_valid and
// in_stall; each request gives exactly one result on the out channel (handle,
// bytes_in_use, bytes_queued, grant_count) under out_valid and out_stall.
// A request reads its zone entry from the table memory at the accepting edge,
// the next edge updates the entry, writes it back and loads the output
// register, raising out_valid. One request is in flight at a time: the memory
// read is followed by the write-back of the same entry, so the next request
// is accepted only once that write-back is done and the output register is
// not held by a stall.
// While the receiver stalls, the result holds in the output register and
// in_stall stays high until the result is taken.
// Reset clears the table valid bits, so every zone reads as all zero
// (budget, counters and handle counter) until it is first written; reset
// also drops any request in flight and any pending result.
`timescale 1ns / 1ps
module zone_bandwidth_reservation_unit #(
  parameter int ZONES = zbr_pkg::ZBR_ZONES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [3:0]  zone,
  input  logic [63:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] handle,
  output logic [63:0] bytes_in_use,
  output logic [63:0] bytes_queued,
  output logic [31:0] grant_count
);
  import zbr_pkg::*;

  localparam int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;

  logic [ZONE_EXT_W-1:0] zone_ext;
  logic                  zone_ok;
  logic [IDX_W-1:0]      zone_idx;
  logic                  accept;

  logic                  s1_valid;
  kind_t                 s1_kind;
  logic [AMT_W-1:0]      s1_amount;
  logic                  s1_zone_ok;
  logic [IDX_W-1:0]      s1_idx;

  entry_t                cur_entry;
  entry_t                new_entry;
  result_t               res;

  assign zone_ext = ZONE_EXT_W'(zone);
  assign zone_ok  = zone_ext < ZONE_EXT_W'(ZONES);
  assign zone_idx = zone_ext[IDX_W-1:0];
  assign in_stall = s1_valid | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_kind <= KIND_STATUS;
    end else if (accept) begin
      s1_kind <= kind_t'(kind);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_amount  <= amount;
      s1_zone_ok <= zone_ok;
      s1_idx     <= zone_idx;
    end
  end

  zbr_table #(
    .ZONES (ZONES)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_idx  (zone_idx),
    .rd_data (cur_entry),
    .wr_en   (s1_valid & s1_zone_ok),
    .wr_idx  (s1_idx),
    .wr_data (new_entry)
  );

  zbr_update u_update (
    .kind    (s1_kind),
    .amount  (s1_amount),
    .zone_ok (s1_zone_ok),
    .cur     (cur_entry),
    .nxt     (new_entry),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      handle       <= res.handle;
      bytes_in_use <= res.in_use;
      bytes_queued <= res.queued;
      grant_count  <= res.grants;
    end
  end

  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request did not reach the update stage");

  a_update_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> out_valid)
    else $error("update did not load the output register");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> !s1_valid)
    else $error("two requests in the update stage back to back");

  a_idle_zone_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && grant_count == '0 |-> bytes_in_use == '0)
    else $error("bytes in use without an outstanding grant");

endmodule
